### src/request_packet_parser_assert.svh
// Assertion macros used by the parser back end (rpp_back)
`ifndef REQUEST_PACKET_PARSER_ASSERT_SVH
`define REQUEST_PACKET_PARSER_ASSERT_SVH

// Next-cycle implication, disabled while rst is high.
`define RPP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

// Same-cycle implication.
`define RPP_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`endif

### src/rpp_pkg.sv
package rpp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  item_kind;
      logic [7:0]  out_byte;
      logic [1:0]  packet_type;
      logic [7:0]  pack_id;
      logic [31:0] session_val;
      logic        has_mod;
      logic signed [63:0] mod_value;
      logic        need_reply;
      logic [31:0] total_size;
      logic [1:0]  error_code;
      logic        last_result;
   } rsp_type;

   localparam logic [2:0] KIND_MODNAME  = 3'd0;
   localparam logic [2:0] KIND_INSTNAME = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
   localparam logic [2:0] KIND_SUMMARY  = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SHORT = 2'd1;
   localparam logic [1:0] ERR_TYPE  = 2'd2;

   localparam logic [1:0] PT_WHOLE = 2'd0;
   localparam logic [1:0] PT_HEAD  = 2'd1;
   localparam logic [1:0] PT_CONT  = 2'd2;
   localparam logic [1:0] PT_END   = 2'd3;

   localparam logic [3:0] TYPE_WHOLE = 4'h1;
   localparam logic [3:0] TYPE_HEAD  = 4'h2;
   localparam logic [3:0] TYPE_CONT  = 4'h4;
   localparam logic [3:0] TYPE_END   = 4'h8;
   localparam logic [7:0] REPLY_MASK = 8'h10;
   localparam logic [7:0] MOD_MASK   = 8'h20;
   localparam logic [7:0] TYPE_MASK  = 8'h0f;

   // Classified request passed from front to back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       first_byte;
   } cls_type;

endpackage

### src/request_packet_parser.sv
// Channel   Handshake     Payload
// req       push/full     rpp_pkg::req_type (data_byte, last_byte)
// rsp       pop/empty     rpp_pkg::rsp_type (one result per pop)
// One request a cycle while full is low; an accepted request is registered in the front
// stage and parsed once the queue has room for two, its up to two results entering together.
// Throughput is one byte per cycle while the queue has room for two results.
// full rises when the queue lacks room for two results and the front stage holds.
// Reset (synchronous) empties the queue and returns the parser to the flag byte.
module request_packet_parser #(
   parameter int Depth = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rpp_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output rpp_pkg::rsp_type rsp_data
);
   logic cls_valid, cls_ready, room2;
   rpp_pkg::cls_type cls_data;
   logic [1:0] wr_count;
   rpp_pkg::rsp_type wr_a, wr_b;

   rpp_front u_front (.clock, .reset, .push, .full, .req_data,
      .cls_valid, .cls_ready, .cls_data);
   rpp_back u_back (.clock, .reset, .cls_valid, .cls_ready, .cls_data,
      .room2, .wr_count, .wr_a, .wr_b);
   rpp_fifo #(.Depth(Depth)) u_fifo (.clock, .reset, .wr_count, .wr_a, .wr_b,
      .room2, .empty, .pop, .rd_data(rsp_data));
endmodule

### src/rpp_front.sv
// Front: tags each request with whether it opens a packet.
module rpp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  rpp_pkg::req_type req_data,
   output logic            cls_valid,
   input  logic            cls_ready,
   output rpp_pkg::cls_type cls_data
);
   logic open_ff, open_in;
   logic v_ff, v_in;
   rpp_pkg::cls_type d_ff, d_in;
   logic take;

   assign full = v_ff && !cls_ready;
   assign take = push && !full;

   always_comb begin
      open_in = open_ff;
      v_in = v_ff;
      d_in = d_ff;
      if (cls_ready) v_in = 1'b0;
      if (take) begin
         v_in = 1'b1;
         d_in.data_byte = req_data.data_byte;
         d_in.last_byte = req_data.last_byte;
         d_in.first_byte = open_ff;
         open_in = req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b1;
         v_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
         v_ff <= v_in;
      end
      d_ff <= d_in;
   end

   assign cls_valid = v_ff;
   assign cls_data = d_ff;
endmodule

### src/rpp_fifo.sv
// Small result queue; pushes up to two entries a cycle.
module rpp_fifo #(
   parameter int Depth = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       wr_count,
   input  rpp_pkg::rsp_type wr_a,
   input  rpp_pkg::rsp_type wr_b,
   output logic             room2,
   output logic             empty,
   input  logic             pop,
   output rpp_pkg::rsp_type rd_data
);
   localparam int AW = $clog2(Depth);
   rpp_pkg::rsp_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic do_pop;

   assign empty = (cnt_ff == '0);
   assign do_pop = pop && !empty;
   assign room2 = (cnt_ff <= (AW+1)'(Depth - 2));
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + AW'(wr_count);
         rp_ff <= rp_ff + AW'(do_pop);
         cnt_ff <= cnt_ff + (AW+1)'(wr_count) - (AW+1)'(do_pop);
      end
      if (wr_count != 2'd0) mem_ff[wp_ff] <= wr_a;
      if (wr_count == 2'd2) mem_ff[wp_ff + AW'(1)] <= wr_b;
   end
endmodule

### src/rpp_back.sv
// Back: field parser state machine.
`include "request_packet_parser_assert.svh"
module rpp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cls_valid,
   output logic             cls_ready,
   input  rpp_pkg::cls_type cls_data,
   input  logic             room2,
   output logic [1:0]       wr_count,
   output rpp_pkg::rsp_type wr_a,
   output rpp_pkg::rsp_type wr_b
);
   localparam logic [3:0] PH_FLAG = 4'd0, PH_PACKID = 4'd1, PH_MODLEN = 4'd2,
      PH_INSTLEN = 4'd3, PH_MODNAME = 4'd4, PH_INSTNAME = 4'd5, PH_SESSION = 4'd6,
      PH_MODNUM = 4'd7, PH_TOTSIZE = 4'd8, PH_PAYLOAD = 4'd9, PH_TAIL = 4'd10;

   logic [3:0] ph_ff, ph_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [1:0] kind_ff, kind_in;
   logic rep_ff, rep_in, mod_ff, mod_in, drop_ff, drop_in;
   logic [7:0] pid_ff, pid_in, mlen_ff, mlen_in, ilen_ff, ilen_in;
   logic [31:0] ses_ff, ses_in, size_ff, size_in;
   logic [63:0] mnum_ff, mnum_in;
   logic go, err, summ, item, last;
   logic [2:0] ikind;
   logic [7:0] b;
   logic [3:0] t;
   logic [7:0] cnt1;
   rpp_pkg::rsp_type first_r, sum_r, short_r;

   assign cls_ready = room2;
   assign go = cls_valid && room2;
   assign b = cls_data.data_byte;
   assign t = b[3:0] & rpp_pkg::TYPE_MASK[3:0];
   assign last = cls_data.last_byte;
   assign cnt1 = cnt_ff + 8'd1;

   always_comb begin
      ph_in = ph_ff; cnt_in = cnt_ff; kind_in = kind_ff; rep_in = rep_ff;
      mod_in = mod_ff; drop_in = drop_ff; pid_in = pid_ff; mlen_in = mlen_ff;
      ilen_in = ilen_ff; ses_in = ses_ff; size_in = size_ff; mnum_in = mnum_ff;
      err = 1'b0; summ = 1'b0; item = 1'b0; ikind = rpp_pkg::KIND_PAYLOAD;
      if (drop_ff) begin
         if (last) begin
            drop_in = 1'b0; ph_in = PH_FLAG; cnt_in = '0;
         end
      end else begin
         unique case (ph_ff)
            PH_FLAG: begin
               rep_in = |(b & rpp_pkg::REPLY_MASK);
               mod_in = |(b & rpp_pkg::MOD_MASK);
               pid_in = '0; mlen_in = '0; ilen_in = '0; ses_in = '0;
               mnum_in = '0; size_in = '0; cnt_in = '0;
               priority if (t == rpp_pkg::TYPE_WHOLE) kind_in = rpp_pkg::PT_WHOLE;
               else if (t == rpp_pkg::TYPE_HEAD) kind_in = rpp_pkg::PT_HEAD;
               else if (t == rpp_pkg::TYPE_CONT) kind_in = rpp_pkg::PT_CONT;
               else if (t == rpp_pkg::TYPE_END) kind_in = rpp_pkg::PT_END;
               else begin
                  kind_in = rpp_pkg::PT_WHOLE; err = 1'b1;
               end
               ph_in = kind_in[1] ? PH_SESSION : PH_PACKID;
               if (err) ph_in = PH_FLAG;
            end
            PH_PACKID: begin pid_in = b; ph_in = PH_MODLEN; end
            PH_MODLEN: begin mlen_in = b; ph_in = PH_INSTLEN; end
            PH_INSTLEN: begin
               ilen_in = b; cnt_in = '0;
               if (mlen_ff != 8'd0) ph_in = PH_MODNAME;
               else if (b != 8'd0) ph_in = PH_INSTNAME;
               else ph_in = PH_SESSION;
            end
            PH_MODNAME: begin
               item = 1'b1; ikind = rpp_pkg::KIND_MODNAME; cnt_in = cnt1;
               if (cnt1 >= mlen_ff) begin
                  cnt_in = '0;
                  ph_in = (ilen_ff != 8'd0) ? PH_INSTNAME : PH_SESSION;
               end
            end
            PH_INSTNAME: begin
               item = 1'b1; ikind = rpp_pkg::KIND_INSTNAME; cnt_in = cnt1;
               if (cnt1 >= ilen_ff) begin
                  cnt_in = '0; ph_in = PH_SESSION;
               end
            end
            PH_SESSION: begin
               ses_in[8*cnt_ff[1:0] +: 8] = b; cnt_in = cnt1;
               if (cnt1 >= 8'd4) begin
                  cnt_in = '0;
                  if (!kind_ff[1] && mod_ff) ph_in = PH_MODNUM;
                  else if (kind_ff == rpp_pkg::PT_HEAD) ph_in = PH_TOTSIZE;
                  else begin summ = 1'b1; ph_in = PH_PAYLOAD; end
               end
            end
            PH_MODNUM: begin
               mnum_in[8*cnt_ff[2:0] +: 8] = b; cnt_in = cnt1;
               if (cnt1 >= 8'd8) begin
                  cnt_in = '0;
                  if (kind_ff == rpp_pkg::PT_HEAD) ph_in = PH_TOTSIZE;
                  else begin summ = 1'b1; ph_in = PH_PAYLOAD; end
               end
            end
            PH_TOTSIZE: begin
               size_in[8*cnt_ff[1:0] +: 8] = b; cnt_in = cnt1;
               if (cnt1 >= 8'd4) begin
                  cnt_in = '0; summ = 1'b1; ph_in = PH_TAIL;
               end
            end
            PH_PAYLOAD: item = 1'b1;
            default: ;
         endcase
         if (err) begin
            if (!last) drop_in = 1'b1;
            cnt_in = '0;
         end else if (last) begin
            ph_in = PH_FLAG; cnt_in = '0;
         end
      end
   end

   // Build results from next-state values (summary fields are complete there).
   always_comb begin
      logic full_pkt;
      full_pkt = !kind_in[1];
      first_r = '0;
      first_r.packet_type = kind_in;
      if (err) begin
         first_r.item_kind = rpp_pkg::KIND_ERROR;
         first_r.error_code = rpp_pkg::ERR_TYPE;
      end else begin
         first_r.item_kind = ikind;
         first_r.out_byte = b;
      end
      sum_r = '0;
      sum_r.item_kind = rpp_pkg::KIND_SUMMARY;
      sum_r.packet_type = kind_in;
      sum_r.pack_id = full_pkt ? pid_in : 8'd0;
      sum_r.session_val = ses_in;
      sum_r.has_mod = full_pkt && mod_in;
      sum_r.mod_value = (full_pkt && mod_in) ? mnum_in : 64'd0;
      sum_r.need_reply = full_pkt && rep_in;
      sum_r.total_size = (kind_in == rpp_pkg::PT_HEAD) ? size_in : 32'd0;
      short_r = '0;
      short_r.item_kind = rpp_pkg::KIND_ERROR;
      short_r.packet_type = kind_in;
      short_r.error_code = rpp_pkg::ERR_SHORT;
   end

   logic p0, p1, need_short;
   always_comb begin
      logic [3:0] php;
      php = ph_ff;
      if (!drop_ff && !err) begin
         if (summ) php = (ph_ff == PH_TOTSIZE) ? PH_TAIL : PH_PAYLOAD;
         else if (ph_ff == PH_PAYLOAD || ph_ff == PH_TAIL) php = ph_ff;
         else php = PH_FLAG;
      end
      need_short = !drop_ff && !err && last && php != PH_PAYLOAD && php != PH_TAIL;
      p0 = !drop_ff && (err || item || summ);
      p1 = need_short;
      wr_count = 2'd0; wr_a = '0; wr_b = '0;
      if (go) begin
         if (p0) begin
            wr_a = summ ? sum_r : first_r;
            wr_a.last_result = last && !p1;
            wr_count = 2'd1;
            if (p1) begin
               wr_b = short_r;
               wr_b.last_result = 1'b1; wr_count = 2'd2;
            end
         end else if (p1) begin
            wr_a = short_r; wr_a.last_result = 1'b1; wr_count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_FLAG; cnt_ff <= '0; kind_ff <= '0; rep_ff <= 1'b0;
         mod_ff <= 1'b0; drop_ff <= 1'b0; pid_ff <= '0; mlen_ff <= '0;
         ilen_ff <= '0; ses_ff <= '0; size_ff <= '0; mnum_ff <= '0;
      end else if (go) begin
         ph_ff <= ph_in; cnt_ff <= cnt_in; kind_ff <= kind_in; rep_ff <= rep_in;
         mod_ff <= mod_in; drop_ff <= drop_in; pid_ff <= pid_in; mlen_ff <= mlen_in;
         ilen_ff <= ilen_in; ses_ff <= ses_in; size_ff <= size_in; mnum_ff <= mnum_in;
      end
   end

   `RPP_ASSERT_NEXT(a_last_to_flag, clock, reset, go && last && !err, ph_ff == PH_FLAG)
   `RPP_ASSERT_NOW(a_drop_no_out, clock, reset, go && drop_ff, wr_count == 2'd0)
   `RPP_ASSERT_NOW(a_open_flag, clock, reset,
      cls_valid && cls_data.first_byte, ph_ff == PH_FLAG && !drop_ff)
endmodule
